FILE: hdl/distance_vector_relax_engine_macros.svh
// Assertion helpers for the engine's controller RTL (dvre_ctrl.sv).
// Each macro expects clk and arst_n in scope.
`ifndef DISTANCE_VECTOR_RELAX_ENGINE_MACROS_SVH
`define DISTANCE_VECTOR_RELAX_ENGINE_MACROS_SVH

// Same-cycle implication
`define DVRE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define DVRE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/dvre_pkg.sv
`default_nettype none
package dvre_pkg;

	localparam int DEF_MAX_NODES   = 64;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;

	// Commands
	localparam logic [2:0] CMD_LOAD     = 3'd0;
	localparam logic [2:0] CMD_INIT     = 3'd1;
	localparam logic [2:0] CMD_RELAX    = 3'd2;
	localparam logic [2:0] CMD_ANNOUNCE = 3'd3;
	localparam logic [2:0] CMD_READ     = 3'd4;

	// Result kinds
	localparam logic KIND_MSG  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

	localparam logic [31:0] INF_DIST = 32'hFFFF_FFFF;
	localparam logic [6:0]  NO_HOP   = 7'd64;
	localparam logic [6:0]  DEF_NODE_COUNT = 7'd64;

	typedef struct packed {
		logic [5:0] dest_node;
		logic [6:0] node_count;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  row_node;
		logic [5:0]  col_node;
		logic [15:0] link_w;
		logic [31:0] neighbour_estimate;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  to_node;
		logic [5:0]  from_node;
		logic [31:0] distance;
		logic [6:0]  next_hop;
		logic        last;
	} result_t;

	// One node entry: pending-update flag, next hop, distance
	typedef struct packed {
		logic        upd;
		logic [6:0]  hop;
		logic [31:0] metric;
	} node_ent_t;

endpackage
`default_nettype wire

FILE: hdl/dvre_ram.sv
`default_nettype none
module dvre_ram #(
	parameter int AW = 6,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [1 << AW];

	// Write port and registered read port; read data holds without rd_en
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/dvre_ctrl.sv
`default_nettype none
`include "distance_vector_relax_engine_macros.svh"
module dvre_ctrl #(
	parameter int MAX_NODES   = dvre_pkg::DEF_MAX_NODES,
	parameter int WEIGHT_BITS = dvre_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dvre_pkg::cfg_t                       cfg,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire dvre_pkg::in_item_t                   in_item,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output dvre_pkg::result_t                         out_item,
	output logic                                      w_wr_en,
	output logic [2*$clog2(MAX_NODES)-1:0]            w_wr_addr,
	output logic [WEIGHT_BITS-1:0]                    w_wr_data,
	output logic                                      w_rd_en,
	output logic [2*$clog2(MAX_NODES)-1:0]            w_rd_addr,
	input  wire logic [WEIGHT_BITS-1:0]               w_rd_data,
	output logic                                      n_wr_en,
	output logic [$clog2(MAX_NODES)-1:0]              n_wr_addr,
	output dvre_pkg::node_ent_t                       n_wr_data,
	output logic                                      n_rd_en,
	output logic [$clog2(MAX_NODES)-1:0]              n_rd_addr,
	input  wire dvre_pkg::node_ent_t                  n_rd_data
);
	import dvre_pkg::*;

	localparam int NB   = $clog2(MAX_NODES);
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int WA_W = 2 * NB;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_RELAX    = 3'd2;
	localparam logic [2:0] ST_ANN_HEAD = 3'd3;
	localparam logic [2:0] ST_SCAN     = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;
	localparam logic [2:0] ST_INIT     = 3'd6;

	logic [2:0]      state_q;
	logic [WA_W-1:0] clr_q;
	logic [NB-1:0]   init_q;
	logic [CW-1:0]   iss_q;
	logic            chk_v_s1;
	logic [NB-1:0]   chk_idx_s1;
	logic            pend_v_q;
	logic [NB-1:0]   pend_idx_q;
	logic            oob_q;
	logic [5:0]      row_q;
	logic [5:0]      col_q;
	logic [31:0]     est_q;
	logic [31:0]     dist_q;
	logic            out_valid_q;
	result_t         out_q;

	logic [CW-1:0]   cnt;
	logic            accept;
	logic            row_in_cnt;
	logic            col_in_cnt;
	logic            row_in_max;
	logic            col_in_max;
	logic            push_ok;
	logic            push;
	result_t         push_item;
	logic [32:0]     sum;
	logic [31:0]     sat_sum;
	logic            relax_better;
	logic            scan_more;
	logic            scan_hit;
	logic            scan_stall;
	logic            scan_issue;
	logic            scan_finish;
	logic            dest_in_cnt;

	// Nodes in use, clamped to the store size
	assign cnt = (32'(cfg.node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(cfg.node_count);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign row_in_cnt = 32'(in_item.row_node) < 32'(cnt);
	assign col_in_cnt = 32'(in_item.col_node) < 32'(cnt);
	assign row_in_max = 32'(in_item.row_node) < MAX_NODES;
	assign col_in_max = 32'(in_item.col_node) < MAX_NODES;
	assign dest_in_cnt = 32'(cfg.dest_node) < 32'(cnt);

	assign push_ok = !out_valid_q || out_ready;

	// Saturating relax sum and compare against the stored distance
	assign sum     = {1'b0, est_q} + 33'(w_rd_data);
	assign sat_sum = (sum >= {1'b0, INF_DIST}) ? INF_DIST : sum[31:0];
	assign relax_better = (w_rd_data != '0) && (est_q != INF_DIST) && (sat_sum < n_rd_data.metric);

	// Announce scan: one weight read issued per cycle unless stalled by a held message, checked the next
	assign scan_more   = iss_q < cnt;
	assign scan_hit    = chk_v_s1 && (w_rd_data != '0);
	assign scan_stall  = scan_hit && pend_v_q && !push_ok;
	assign scan_issue  = (state_q == ST_SCAN) && !scan_stall && scan_more;
	assign scan_finish = !chk_v_s1 && !scan_more;

	// Memory ports and result push
	always_comb begin
		w_wr_en   = 1'b0;
		w_wr_addr = {NB'(in_item.row_node), NB'(in_item.col_node)};
		w_wr_data = WEIGHT_BITS'(in_item.link_w);
		w_rd_en   = 1'b0;
		w_rd_addr = {NB'(in_item.row_node), NB'(in_item.col_node)};
		n_wr_en   = 1'b0;
		n_wr_addr = NB'(row_q);
		n_wr_data = '{upd: 1'b0, hop: NO_HOP, metric: INF_DIST};
		n_rd_en   = 1'b0;
		n_rd_addr = NB'(in_item.row_node);
		push      = 1'b0;
		push_item = '{kind: KIND_MSG, to_node: 6'(pend_idx_q), from_node: row_q,
			distance: dist_q, next_hop: NO_HOP, last: 1'b0};
		unique case (state_q)
			ST_CLEAR: begin
				w_wr_en   = 1'b1;
				w_wr_addr = clr_q;
				w_wr_data = '0;
				n_wr_en   = 1'b1;
				n_wr_addr = clr_q[NB-1:0];
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_item.cmd)
						CMD_LOAD: w_wr_en = row_in_max && col_in_max;
						CMD_RELAX: begin
							w_rd_en = row_in_cnt && col_in_cnt;
							n_rd_en = row_in_cnt && col_in_cnt;
						end
						CMD_ANNOUNCE: n_rd_en = row_in_cnt;
						CMD_READ: n_rd_en = row_in_max;
						default: begin
						end
					endcase
				end
			end
			ST_RELAX: begin
				n_wr_en   = relax_better;
				n_wr_data = '{upd: 1'b1, hop: 7'(col_q), metric: sat_sum};
			end
			ST_ANN_HEAD: begin
				// clear the flag now; nothing else touches the entry during the scan
				n_wr_en   = n_rd_data.upd;
				n_wr_data = '{upd: 1'b0, hop: n_rd_data.hop, metric: n_rd_data.metric};
			end
			ST_SCAN: begin
				w_rd_en   = scan_issue;
				w_rd_addr = {NB'(iss_q), NB'(row_q)};
				if (scan_hit && pend_v_q && push_ok) begin
					push = 1'b1;
				end else if (scan_finish && pend_v_q && push_ok) begin
					push           = 1'b1;
					push_item.last = 1'b1;
				end
			end
			ST_READ: begin
				push      = push_ok;
				push_item = '{kind: KIND_READ, to_node: row_q, from_node: row_q,
					distance: oob_q ? INF_DIST : n_rd_data.metric,
					next_hop: oob_q ? NO_HOP : n_rd_data.hop, last: 1'b1};
			end
			ST_INIT: begin
				n_wr_en   = 1'b1;
				n_wr_addr = init_q;
				n_wr_data = '{upd: 1'b1, hop: NO_HOP,
					metric: (dest_in_cnt && (32'(init_q) == 32'(cfg.dest_node))) ? '0 : INF_DIST};
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			init_q     <= '0;
			iss_q      <= '0;
			chk_v_s1   <= 1'b0;
			pend_v_q   <= 1'b0;
			oob_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_item.cmd)
							CMD_INIT: begin
								init_q  <= '0;
								state_q <= ST_INIT;
							end
							CMD_RELAX: begin
								if (row_in_cnt && col_in_cnt) begin
									state_q <= ST_RELAX;
								end
							end
							CMD_ANNOUNCE: begin
								if (row_in_cnt) begin
									state_q <= ST_ANN_HEAD;
								end
							end
							CMD_READ: begin
								oob_q   <= !row_in_max;
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RELAX: state_q <= ST_IDLE;
				ST_ANN_HEAD: begin
					iss_q    <= '0;
					chk_v_s1 <= 1'b0;
					pend_v_q <= 1'b0;
					state_q  <= n_rd_data.upd ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						chk_v_s1 <= scan_issue;
						if (scan_issue) begin
							iss_q <= iss_q + 1'b1;
						end
						if (scan_hit) begin
							pend_v_q <= 1'b1;
						end
					end
					if (scan_finish && (!pend_v_q || push_ok)) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (32'(init_q) == MAX_NODES - 1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the item's operands and scan indexes
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_item.row_node;
			col_q <= in_item.col_node;
			est_q <= in_item.neighbour_estimate;
		end
		if (state_q == ST_ANN_HEAD) begin
			dist_q <= n_rd_data.metric;
		end
		if (scan_issue) begin
			chk_idx_s1 <= NB'(iss_q);
		end
		if ((state_q == ST_SCAN) && !scan_stall && scan_hit) begin
			pend_idx_q <= chk_idx_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`DVRE_ASSERT_IMP(a_push_slot_free, push && out_valid_q, out_ready, "result pushed over an untaken item")
	`DVRE_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, iss_q <= cnt, "scan index past node count")
	`DVRE_ASSERT_NXT(a_relax_single, state_q == ST_RELAX, state_q == ST_IDLE, "relax did not finish")
	`DVRE_ASSERT_IMP(a_weight_write, w_wr_en, (state_q == ST_IDLE) || (state_q == ST_CLEAR), "weight write outside load or clear")

endmodule
`default_nettype wire

FILE: hdl/distance_vector_relax_engine.sv
// Channel   Direction  Contents
// s_*       in         command item: tdata = cmd, row_node, col_node, link_w,
//                      neighbour_estimate
// m_*       out        result item: tdata = to_node, from_node, distance, next_hop;
//                      tuser = kind; tlast = last
// cfg_*     in         register write: cfg_index selects dest_node or node_count
//
// After reset a clearing pass over every weight address zeroes the weight store and sets each
// node table entry to infinite distance and no hop; no item is taken meanwhile, cfg writes are.
// Relax reads the weight and node entry, then writes a better distance; read waits for the
// output register to be free; initialise writes every node entry. Announce reads one
// weight-store entry per scanned node and stalls while a message waits in the output register.
`default_nettype none
module distance_vector_relax_engine #(
	parameter int MAX_NODES   = dvre_pkg::DEF_MAX_NODES,
	parameter int WEIGHT_BITS = dvre_pkg::DEF_WEIGHT_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [2:0] cmd, [8:3] row_node, [14:9] col_node, [30:15] link_w,
	// [62:31] neighbour_estimate, [63] zero
	input  wire logic [dvre_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [5:0] to_node, [11:6] from_node, [43:12] distance, [50:44] next_hop, [55:51] zero
	output logic [dvre_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// [0] kind
	output logic [0:0]                                m_tuser,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dvre_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dvre_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import dvre_pkg::*;

	localparam int NB   = $clog2(MAX_NODES);
	localparam int WA_W = 2 * NB;

	cfg_t             cfg_q;
	in_item_t         in_item;
	result_t          out_item;
	logic             w_wr_en;
	logic [WA_W-1:0]  w_wr_addr;
	logic [WEIGHT_BITS-1:0] w_wr_data;
	logic             w_rd_en;
	logic [WA_W-1:0]  w_rd_addr;
	logic [WEIGHT_BITS-1:0] w_rd_data;
	logic             n_wr_en;
	logic [NB-1:0]    n_wr_addr;
	node_ent_t        n_wr_data;
	logic             n_rd_en;
	logic [NB-1:0]    n_rd_addr;
	node_ent_t        n_rd_data;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_node  <= '0;
			cfg_q.node_count <= DEF_NODE_COUNT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEST:  cfg_q.dest_node  <= cfg_data[5:0];
				REG_COUNT: cfg_q.node_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Unpack the input item
	assign in_item.cmd                = s_tdata[2:0];
	assign in_item.row_node           = s_tdata[8:3];
	assign in_item.col_node           = s_tdata[14:9];
	assign in_item.link_w             = s_tdata[30:15];
	assign in_item.neighbour_estimate = s_tdata[62:31];

	dvre_ram #(
		.AW (WA_W),
		.DW (WEIGHT_BITS)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (w_wr_en),
		.wr_addr (w_wr_addr),
		.wr_data (w_wr_data),
		.rd_en   (w_rd_en),
		.rd_addr (w_rd_addr),
		.rd_data (w_rd_data)
	);

	dvre_ram #(
		.AW (NB),
		.DW ($bits(node_ent_t))
	) u_node_ram (
		.clk     (clk),
		.wr_en   (n_wr_en),
		.wr_addr (n_wr_addr),
		.wr_data (n_wr_data),
		.rd_en   (n_rd_en),
		.rd_addr (n_rd_addr),
		.rd_data (n_rd_data)
	);

	dvre_ctrl #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item),
		.w_wr_en   (w_wr_en),
		.w_wr_addr (w_wr_addr),
		.w_wr_data (w_wr_data),
		.w_rd_en   (w_rd_en),
		.w_rd_addr (w_rd_addr),
		.w_rd_data (w_rd_data),
		.n_wr_en   (n_wr_en),
		.n_wr_addr (n_wr_addr),
		.n_wr_data (n_wr_data),
		.n_rd_en   (n_rd_en),
		.n_rd_addr (n_rd_addr),
		.n_rd_data (n_rd_data)
	);

	// Pack the result item
	assign m_tdata = {5'b0, out_item.next_hop, out_item.distance, out_item.from_node,
		out_item.to_node};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

endmodule
`default_nettype wire

FILE: verif/distance_vector_relax_engine_chk.sv
`timescale 1ns / 100ps
module distance_vector_relax_engine_chk (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	// [2:0] cmd, [8:3] row_node, [14:9] col_node, [30:15] link_w,
	// [62:31] neighbour_estimate, [63] zero
	input  wire logic [dvre_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	// [5:0] to_node, [11:6] from_node, [43:12] distance, [50:44] next_hop, [55:51] zero
	input  wire logic [dvre_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] kind
	input  wire logic [0:0]                         m_tuser,
	input  wire logic                               m_tlast,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [dvre_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dvre_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                      mismatch_cnt,
	output int                                      routes_pending
);
	import dvre_pkg::*;

	// Shadow copy of the engine: weights, per-node distance, hop and pending flag
	logic [15:0] edge_w [0:4095];
	logic [31:0] node_dist [0:63];
	logic [6:0]  node_hop [0:63];
	bit          node_dirty [0:63];
	logic [5:0]  dest_q;
	logic [6:0]  count_q;
	result_t     expected_routes [$];

	// Apply one command item to the shadow state and queue the results it causes
	task automatic model_route_cmd(input logic [IN_TDATA_W-1:0] word);
		logic [2:0]  cmd;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [15:0] w;
		logic [31:0] est;
		logic [32:0] sum;
		int          span;
		bit          held;
		result_t     prev;
		cmd  = word[2:0];
		row  = word[8:3];
		col  = word[14:9];
		w    = word[30:15];
		est  = word[62:31];
		span = (count_q > 7'd64) ? 64 : int'(count_q);
		held = 1'b0;
		prev = '0;
		case (cmd)
			// weight field is exactly WEIGHT_BITS wide, so no masking
			CMD_LOAD: edge_w[{row, col}] = w;
			CMD_INIT: begin
				for (int i = 0; i < 64; i++) begin
					node_dist[i]  = INF_DIST;
					node_hop[i]   = NO_HOP;
					node_dirty[i] = 1'b1;
				end
				if (dest_q < span)
					node_dist[dest_q] = '0;
			end
			CMD_RELAX: begin
				if (row < span && col < span && edge_w[{row, col}] != '0 &&
						est != INF_DIST) begin
					sum = {1'b0, est} + {17'd0, edge_w[{row, col}]};
					// saturate to infinity
					if (sum >= {1'b0, INF_DIST})
						sum = {1'b0, INF_DIST};
					if (sum[31:0] < node_dist[row]) begin
						node_dist[row]  = sum[31:0];
						node_hop[row]   = {1'b0, col};
						node_dirty[row] = 1'b1;
					end
				end
			end
			CMD_ANNOUNCE: begin
				if (row < span && node_dirty[row]) begin
					// hold each message back one step so the final one can take last
					for (int i = 0; i < span; i++) begin
						if (edge_w[{6'(i), row}] != '0) begin
							if (held)
								expected_routes.push_back(prev);
							prev.kind      = KIND_MSG;
							prev.to_node   = 6'(i);
							prev.from_node = row;
							prev.distance  = node_dist[row];
							prev.next_hop  = NO_HOP;
							prev.last      = 1'b0;
							held = 1'b1;
						end
					end
					if (held) begin
						prev.last = 1'b1;
						expected_routes.push_back(prev);
					end
					node_dirty[row] = 1'b0;
				end
			end
			CMD_READ: begin
				prev.kind      = KIND_READ;
				prev.to_node   = row;
				prev.from_node = row;
				prev.distance  = node_dist[row];
				prev.next_hop  = node_hop[row];
				prev.last      = 1'b1;
				expected_routes.push_back(prev);
			end
			default: ;
		endcase
	endtask

	// Compare accepted results, then advance the shadow state
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4096; i++)
				edge_w[i] = '0;
			for (int i = 0; i < 64; i++) begin
				node_dist[i]  = INF_DIST;
				node_hop[i]   = NO_HOP;
				node_dirty[i] = 1'b0;
			end
			dest_q  = '0;
			count_q = DEF_NODE_COUNT;
			expected_routes.delete();
			mismatch_cnt   = 0;
			routes_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind      = m_tuser[0];
				got.to_node   = m_tdata[5:0];
				got.from_node = m_tdata[11:6];
				got.distance  = m_tdata[43:12];
				got.next_hop  = m_tdata[50:44];
				got.last      = m_tlast;
				if (expected_routes.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t unexpected result: kind=%0d to=%0d from=%0d dist=%h hop=%0d last=%0d",
							$realtime, got.kind, got.to_node, got.from_node, got.distance,
							got.next_hop, got.last);
					mismatch_cnt++;
				end else begin
					want = expected_routes.pop_front();
					if (got !== want) begin
						if (mismatch_cnt < 10) begin
							$display("%0t result mismatch: expected kind=%0d to=%0d from=%0d dist=%h hop=%0d last=%0d",
								$realtime, want.kind, want.to_node, want.from_node,
								want.distance, want.next_hop, want.last);
							$display("                   actual   kind=%0d to=%0d from=%0d dist=%h hop=%0d last=%0d",
								got.kind, got.to_node, got.from_node, got.distance,
								got.next_hop, got.last);
						end
						mismatch_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DEST)
					dest_q = cfg_data[5:0];
				else if (cfg_index == REG_COUNT)
					count_q = cfg_data;
			end
			if (s_tvalid && s_tready)
				model_route_cmd(s_tdata);
			routes_pending = expected_routes.size();
		end
	end

endmodule

FILE: verif/distance_vector_relax_engine_tb.sv
`timescale 1ns / 100ps
module distance_vector_relax_engine_tb;
	import dvre_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT     = 20000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 200;
	localparam int RANDOM_ITEMS    = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// [2:0] cmd, [8:3] row_node, [14:9] col_node, [30:15] link_w,
	// [62:31] neighbour_estimate, [63] zero
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	// [5:0] to_node, [11:6] from_node, [43:12] distance, [50:44] next_hop, [55:51] zero
	logic [OUT_TDATA_W-1:0]  m_tdata;
	// [0] kind
	logic [0:0]              m_tuser;
	logic                    m_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int mismatch_cnt;
	int routes_pending;
	int idle_cycles;
	int items_sent;
	bit sender_fast;
	bit hold_off_req;
	int edge_src [$];
	int edge_dst [$];

	distance_vector_relax_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	distance_vector_relax_engine_chk chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_cnt   (mismatch_cnt),
		.routes_pending (routes_pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort when no channel moves an item for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("distance_vector_relax_engine test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one command item after a random gap (none when sender_fast); return at the falling edge after acceptance
	task automatic send_cmd(input int unsigned cmd, input int unsigned row,
			input int unsigned col, input int unsigned w, input bit [31:0] est);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, est, 16'(w), 6'(col), 6'(row), 3'(cmd)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 7'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write both registers in random order, then drop valid
	task automatic write_regs(input int dest, input int count);
		bit dest_first;
		dest_first = $urandom_range(0, 1);
		if (dest_first) begin
			put_reg(REG_DEST, dest);
			put_reg(REG_COUNT, count);
		end else begin
			put_reg(REG_COUNT, count);
			put_reg(REG_DEST, dest);
		end
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, drain every expected result, then let the engine finish silent work
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (routes_pending == 0);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic int unsigned pick_weight();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 16'hFFFF;
		return $urandom_range(1, 40);
	endfunction

	function automatic bit [31:0] pick_estimate();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return INF_DIST;
		if (sel == 1)
			return $urandom;
		if (sel == 2)
			return INF_DIST - $urandom_range(0, 70000);
		return $urandom_range(0, 300);
	endfunction

	// Load a weight and remember real edges for later relax and announce picks
	task automatic load_edge(input int row, input int col);
		int unsigned w;
		w = pick_weight();
		send_cmd(CMD_LOAD, row, col, w, $urandom);
		if (w != 0) begin
			edge_src.push_back(row);
			edge_dst.push_back(col);
		end
	endtask

	// One setting: build a graph, initialise, then mix relax, announce, read and noise
	task automatic run_phase(input int count, input int dest);
		int n_loads;
		int n_ops;
		int sel;
		int k;
		write_regs(dest, count);
		sender_fast = ($urandom_range(0, 3) == 0);
		edge_src.delete();
		edge_dst.delete();
		n_loads = (count == 64) ? 40 : 2 * count;
		repeat (n_loads)
			load_edge($urandom_range(0, count - 1), $urandom_range(0, count - 1));
		send_cmd(CMD_INIT, $urandom, $urandom, $urandom, $urandom);
		n_ops = $urandom_range(40, 60);
		repeat (n_ops) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				if (edge_src.size() > 0 && $urandom_range(0, 3) != 0) begin
					k = $urandom_range(0, edge_src.size() - 1);
					send_cmd(CMD_RELAX, edge_src[k], edge_dst[k], $urandom, pick_estimate());
				end else begin
					send_cmd(CMD_RELAX, $urandom_range(0, count - 1),
						$urandom_range(0, count - 1), $urandom, pick_estimate());
				end
			end else if (sel < 73) begin
				if (edge_dst.size() > 0 && $urandom_range(0, 1) == 0) begin
					k = $urandom_range(0, edge_dst.size() - 1);
					send_cmd(CMD_ANNOUNCE, edge_dst[k], $urandom, $urandom, $urandom);
				end else if ($urandom_range(0, 7) == 0) begin
					send_cmd(CMD_ANNOUNCE, $urandom_range(0, 63), $urandom, $urandom, $urandom);
				end else begin
					send_cmd(CMD_ANNOUNCE, $urandom_range(0, count - 1), $urandom, $urandom,
						$urandom);
				end
			end else if (sel < 85) begin
				send_cmd(CMD_READ, $urandom_range(0, 63), $urandom, $urandom, $urandom);
			end else if (sel < 90) begin
				load_edge($urandom_range(0, count - 1), $urandom_range(0, count - 1));
			end else if (sel < 92) begin
				send_cmd(CMD_INIT, $urandom, $urandom, $urandom, $urandom);
			end else begin
				// noise: any command, any fields
				send_cmd($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom);
			end
		end
		settle();
	endtask

	// Result sink: random stalls, bursts of full readiness, one long hold-off on request
	initial begin : result_sink
		int gap;
		bit burst;
		burst    = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				gap = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end else if (burst) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 15);
			end
			if ($urandom_range(0, 19) == 0)
				burst = !burst;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int sel;
		int count;
		int dest;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		idle_cycles  = 0;
		items_sent   = 0;
		sender_fast  = 1'b0;
		hold_off_req = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: small graph over eight nodes, destination 2
		write_regs(2, 8);
		send_cmd(CMD_READ, 63, 63, 16'hFFFF, INF_DIST);
		send_cmd(CMD_LOAD, 0, 2, 5, 0);
		send_cmd(CMD_LOAD, 1, 0, 16'hFFFF, INF_DIST);
		send_cmd(CMD_LOAD, 3, 0, 7, 0);
		send_cmd(CMD_LOAD, 4, 2, 1, 0);
		send_cmd(CMD_LOAD, 6, 6, 2, 0);
		send_cmd(CMD_LOAD, 9, 0, 3, 0);
		send_cmd(CMD_LOAD, 7, 5, 9, 0);
		send_cmd(CMD_LOAD, 7, 5, 0, 0);
		send_cmd(CMD_LOAD, 63, 63, 16'hFFFF, INF_DIST);
		send_cmd(CMD_INIT, 0, 0, 0, 0);
		// destination fans out to its in-neighbours, then has nothing pending
		send_cmd(CMD_ANNOUNCE, 2, 0, 0, 0);
		send_cmd(CMD_ANNOUNCE, 2, 0, 0, 0);
		send_cmd(CMD_RELAX, 0, 2, 0, 0);
		send_cmd(CMD_RELAX, 0, 2, 0, INF_DIST);
		send_cmd(CMD_RELAX, 0, 1, 0, 0);
		// sum hits infinity and saturates, then one just below it
		send_cmd(CMD_RELAX, 1, 0, 0, 32'hFFFF_0000);
		send_cmd(CMD_RELAX, 1, 0, 0, 32'hFFFE_FFFF);
		send_cmd(CMD_RELAX, 7, 5, 0, 0);
		send_cmd(CMD_RELAX, 9, 0, 0, 0);
		send_cmd(CMD_RELAX, 0, 63, 0, 0);
		send_cmd(CMD_ANNOUNCE, 60, 0, 0, 0);
		send_cmd(CMD_ANNOUNCE, 0, 0, 0, 0);
		send_cmd(CMD_ANNOUNCE, 6, 0, 0, 0);
		send_cmd(CMD_ANNOUNCE, 3, 0, 0, 0);
		send_cmd(CMD_UNUSED, 63, 63, 16'hFFFF, INF_DIST);
		send_cmd(CMD_READ, 0, 0, 0, 0);
		send_cmd(CMD_READ, 1, 0, 0, 0);
		send_cmd(CMD_READ, 2, 0, 0, 0);
		settle();

		// Back-pressure: every node feeds node 7, sink holds off during the fan-out
		write_regs($urandom_range(0, 63), 64);
		sender_fast = 1'b1;
		for (int i = 0; i < 64; i++)
			send_cmd(CMD_LOAD, i, 7, $urandom_range(1, 16'hFFFF), $urandom);
		send_cmd(CMD_INIT, $urandom, $urandom, $urandom, $urandom);
		hold_off_req = 1'b1;
		send_cmd(CMD_ANNOUNCE, 7, $urandom, $urandom, $urandom);
		repeat (24)
			send_cmd(CMD_READ, $urandom_range(0, 63), $urandom, $urandom, $urandom);
		for (int i = 0; i < 64; i += 4)
			send_cmd(CMD_ANNOUNCE, i, $urandom, $urandom, $urandom);
		settle();

		// Random settings, the extremes first
		for (int p = 0; p < 3 || items_sent < RANDOM_ITEMS; p++) begin
			if (p == 0) begin
				run_phase(1, 0);
			end else if (p == 1) begin
				run_phase(64, 63);
			end else begin
				sel   = $urandom_range(0, 9);
				count = (sel == 0) ? 1 : (sel == 1) ? 64 : $urandom_range(2, 12);
				dest  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
					$urandom_range(0, count - 1);
				run_phase(count, dest);
			end
		end

		if (mismatch_cnt == 0 && routes_pending == 0)
			$display("distance_vector_relax_engine test passed");
		else
			$display("distance_vector_relax_engine test failed");
		$finish;
	end

endmodule
